FILE: rtl/core/ple_pkg.sv
// Shared types and codes for the positional list engine.
package ple_pkg;

  // Operation codes carried on the input word.
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_CLEAR  = 2'd2
  } ple_func_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_NOTFOUND = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_EMPTY    = 2'd3
  } ple_status_e;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 7;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp_en;  // latch this cell's match bit
    logic ins_en;  // perform an insert shift
    logic del_en;  // perform a delete shift
  } ple_ctl_t;

endpackage

FILE: rtl/core/ple_if.sv
// Handshake channels for the input word and the result word.
interface ple_in_if import ple_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               func;
  logic signed [ValueW-1:0] value;
  logic [PosW-1:0]          position;

  modport source (output valid, output func, output value, output position, input ready);
  modport sink   (input valid, input func, input value, input position, output ready);
endinterface

interface ple_out_if import ple_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      status;
  logic [PosW-1:0] where;
  logic [PosW-1:0] count;

  modport source (output valid, output status, output where, output count, input ready);
  modport sink   (input valid, input status, input where, input count, output ready);
endinterface

FILE: rtl/core/positional_list_engine_unit.sv
// Top level: sequencer, fill counter, result register and the chain of list cells.
// In each operation the accept cycle latches a match bit in every cell;
// the next cycle performs any insert or delete shift and loads the result register.
// A new word is accepted only while idle, with no result left waiting untaken.
// Result valid is registered and rises once the shift step has loaded the result register.
// Reset empties the list (fill count zero) and drops any pending result; entries keep no reset.
module positional_list_engine_unit import ple_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  ple_in_if.sink    in_i,
  ple_out_if.source out_o
);

  localparam int unsigned FW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (FW > PosW) ? FW : PosW;
  localparam logic [FW-1:0] CapV = FW'(CAPACITY);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic              state_q, state_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic [1:0]        op_q;
  logic [ValueW-1:0] val_q;
  logic [FW-1:0]     pos_q, pos_clamp;
  logic              out_valid_q;
  logic [1:0]        status_q, status_d;
  logic [PosW-1:0]   where_q, where_d;
  logic [PosW-1:0]   count_q;
  logic              accept, full, found;
  ple_ctl_t          ctl;
  logic [FW-1:0]     where_hit;

  logic [ValueW-1:0] entry_w [CAPACITY];
  logic [FW-1:0]     where_w [CAPACITY];
  logic [CAPACITY:0] hit_w;

  assign in_i.ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (fill_q == CapV);

  // Clamp the insert position to the current count.
  assign pos_clamp = (CW'(in_i.position) > CW'(fill_q)) ? fill_q : FW'(in_i.position);

  // Control broadcast to the cells.
  assign ctl.cmp_en = accept;
  assign ctl.ins_en = (state_q == S_EXEC) && (op_q == FUNC_INSERT) && !full;
  assign ctl.del_en = (state_q == S_EXEC) && (op_q == FUNC_DELETE);

  // Chain of cells.
  assign hit_w[0] = 1'b0;
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ValueW-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = val_q;
    end else begin : g_mid
      assign left = entry_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = entry_w[g];
    end else begin : g_inner
      assign right = entry_w[g+1];
    end
    ple_cell #(.FW(FW), .IDX(g)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .cmp_value_i (in_i.value),
      .ins_value_i (val_q),
      .pos_i       (pos_q),
      .fill_i      (fill_q),
      .left_i      (left),
      .right_i     (right),
      .hit_i       (hit_w[g]),
      .hit_o       (hit_w[g+1]),
      .entry_o     (entry_w[g]),
      .where_o     (where_w[g])
    );
  end

  assign found = hit_w[CAPACITY];

  // At most one cell reports a first match, so an OR gathers its position.
  always_comb begin
    where_hit = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      where_hit = where_hit | where_w[i];
    end
  end

  // Result and next fill count for the operation in flight.
  always_comb begin
    fill_d   = fill_q;
    status_d = STAT_DONE;
    where_d  = '0;
    unique case (op_q)
      FUNC_INSERT: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          fill_d  = fill_q + FW'(1);
          where_d = PosW'(CW'(pos_q) + CW'(1));
        end
      end
      FUNC_DELETE: begin
        if (fill_q == '0) begin
          status_d = STAT_EMPTY;
        end else if (!found) begin
          status_d = STAT_NOTFOUND;
        end else begin
          fill_d  = fill_q - FW'(1);
          where_d = PosW'(CW'(where_hit));
        end
      end
      FUNC_CLEAR: begin
        fill_d = '0;
      end
      default: begin
        fill_d = fill_q;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_EXEC;
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EXEC) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Operation word and result word registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= in_i.func;
      val_q <= in_i.value;
      pos_q <= pos_clamp;
    end
    if (state_q == S_EXEC) begin
      status_q <= status_d;
      where_q  <= where_d;
      count_q  <= PosW'(CW'(fill_d));
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.status = status_q;
  assign out_o.where  = where_q;
  assign out_o.count  = count_q;

  // The fill count never passes the capacity.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CapV) else $error("fill count above capacity");

  // An accepted word always moves to the execute step.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC)) else $error("accept without execute");

  // The execute step always leaves a result waiting.
  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |=> out_valid_q) else $error("execute without result");

  // No word is taken while one is being executed.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> !in_i.ready) else $error("ready during execute");

endmodule

FILE: rtl/core/ple_cell.sv
// One list slot: holds an entry, compares it and shifts with its neighbors.
module ple_cell import ple_pkg::*; #(
  parameter int unsigned FW  = 7,
  parameter int unsigned IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ple_ctl_t          ctl_i,
  input  logic [ValueW-1:0] cmp_value_i,
  input  logic [ValueW-1:0] ins_value_i,
  input  logic [FW-1:0]     pos_i,
  input  logic [FW-1:0]     fill_i,
  input  logic [ValueW-1:0] left_i,
  input  logic [ValueW-1:0] right_i,
  input  logic              hit_i,
  output logic              hit_o,
  output logic [ValueW-1:0] entry_o,
  output logic [FW-1:0]     where_o
);

  localparam logic [FW-1:0] IdxV  = FW'(IDX);
  localparam logic [FW-1:0] IdxP1 = FW'(IDX + 1);

  logic [ValueW-1:0] entry_q, entry_d;
  logic              match_q, match_d;
  logic              first;

  // Match bit, taken only for slots that hold a live entry.
  assign match_d = (entry_q == cmp_value_i) && (IdxV < fill_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctl_i.cmp_en) begin
      match_q <= match_d;
    end
  end

  // The hit chain marks this slot and every slot after the first match.
  assign hit_o   = hit_i | match_q;
  assign first   = match_q & ~hit_i;
  assign where_o = first ? IdxP1 : '0;

  // Insert shifts right above the position; delete shifts left from the hit.
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins_en) begin
      if (IdxV > pos_i) begin
        entry_d = left_i;
      end else if (IdxV == pos_i) begin
        entry_d = ins_value_i;
      end
    end else if (ctl_i.del_en && hit_o) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the positional list engine: driver, monitor and list predictor.
module tb_top;
  import ple_pkg::*;

  localparam int Capacity     = 64;
  localparam int RxHoldCycles = 400;
  localparam int DrainCycles  = 8;

  // Unused operation code; the block treats it as a no-op.
  localparam logic [1:0] FuncNop = 2'd3;

  // One input word and one result word as the testbench sees them.
  typedef struct {
    logic [1:0]               func;
    logic signed [ValueW-1:0] value;
    logic [PosW-1:0]          position;
  } list_cmd_t;

  typedef struct {
    ple_status_e     status;
    logic [PosW-1:0] where;
    logic [PosW-1:0] count;
  } list_reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Driven copies of the channel inputs, known from time zero.
  logic                     tx_valid    = 1'b0;
  logic [1:0]               tx_func     = FUNC_INSERT;
  logic signed [ValueW-1:0] tx_value    = '0;
  logic [PosW-1:0]          tx_position = '0;
  logic                     rx_ready    = 1'b0;

  // Traffic shaping, changed only on falling edges.
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          rx_hold      = 1'b0;
  bit          hold_trigger = 1'b0;

  list_cmd_t                cmd_q[$];
  list_reply_t              reply_q[$];
  logic signed [ValueW-1:0] list_model[$];
  int                       errors = 0;

  ple_in_if  in_if ();
  ple_out_if out_if ();

  assign in_if.valid    = tx_valid;
  assign in_if.func     = tx_func;
  assign in_if.value    = tx_value;
  assign in_if.position = tx_position;
  assign out_if.ready   = rx_ready;

  positional_list_engine_unit #(.CAPACITY(Capacity)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Applies one operation to the list copy and returns the result it should produce.
  function automatic list_reply_t apply_list_op(list_cmd_t c);
    list_reply_t r;
    int          slot;
    int          hit;
    r.status = STAT_DONE;
    r.where  = '0;
    hit      = -1;
    case (c.func)
      FUNC_INSERT: begin
        if (list_model.size() >= Capacity) begin
          r.status = STAT_FULL;
        end else begin
          slot = (int'(c.position) > list_model.size()) ? list_model.size() : int'(c.position);
          list_model.insert(slot, c.value);
          r.where = PosW'(slot + 1);
        end
      end
      FUNC_DELETE: begin
        if (list_model.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          for (int i = 0; i < list_model.size(); i++) begin
            if (hit < 0 && list_model[i] == c.value) hit = i;
          end
          if (hit < 0) begin
            r.status = STAT_NOTFOUND;
          end else begin
            list_model.delete(hit);
            r.where = PosW'(hit + 1);
          end
        end
      end
      FUNC_CLEAR: begin
        list_model.delete();
      end
      default: begin
      end
    endcase
    r.count = PosW'(list_model.size());
    return r;
  endfunction

  // Values drawn mostly from a small pool so that deletes hit and duplicates occur.
  function automatic logic signed [ValueW-1:0] pick_value();
    logic signed [ValueW-1:0] pool[8];
    pool = '{32'sd0, 32'sd1, -32'sd1, 32'sd7, 32'sd42, 32'sh7fffffff, 32'sh80000000,
             32'sh5a5a5a5a};
    if ($urandom_range(0, 99) < 70) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Random word with the given mix of insert, delete and clear; the rest are no-ops.
  function automatic list_cmd_t rand_cmd(int unsigned ins_pct, int unsigned del_pct,
                                         int unsigned clr_pct);
    list_cmd_t   c;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) c.func = FUNC_INSERT;
    else if (roll < ins_pct + del_pct) c.func = FUNC_DELETE;
    else if (roll < ins_pct + del_pct + clr_pct) c.func = FUNC_CLEAR;
    else c.func = FuncNop;
    c.value = pick_value();
    roll    = $urandom_range(0, 9);
    if (roll < 6) c.position = PosW'($urandom_range(0, Capacity));
    else if (roll < 8) c.position = '0;
    else c.position = PosW'($urandom_range(0, 127));
    return c;
  endfunction

  task automatic add_cmd(logic [1:0] func, logic signed [ValueW-1:0] value,
                         logic [PosW-1:0] position);
    list_cmd_t c;
    c.func     = func;
    c.value    = value;
    c.position = position;
    cmd_q.push_back(c);
  endtask

  // Waits until every queued word went in and every result came back.
  task automatic wait_drained();
    while (cmd_q.size() != 0 || tx_valid || reply_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic run_phase(int n, int unsigned ins_pct, int unsigned del_pct,
                           int unsigned clr_pct, int unsigned idle, int unsigned stall);
    @(negedge clk_i);
    tx_idle_pct  = idle;
    rx_stall_pct = stall;
    repeat (n) cmd_q.push_back(rand_cmd(ins_pct, del_pct, clr_pct));
    wait_drained();
  endtask

  // Driver: offers the next pending word, holding it until the block takes it.
  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    list_cmd_t nxt;
    if (!rst_ni) begin
      tx_valid <= 1'b0;
    end else if (!tx_valid || in_if.ready) begin
      if (cmd_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        nxt = cmd_q.pop_front();
        tx_valid    <= 1'b1;
        tx_func     <= nxt.func;
        tx_value    <= nxt.value;
        tx_position <= nxt.position;
      end else begin
        tx_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, forced low during a long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_ready <= 1'b0;
    end else begin
      rx_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Monitor: checks each result word, then predicts for each accepted input word.
  always @(posedge clk_i) begin : watch_words
    list_reply_t exp_r;
    list_cmd_t   seen;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (reply_q.size() == 0) begin
          $display("%0t: result with none expected: status %0d where %0d count %0d",
                   $time, out_if.status, out_if.where, out_if.count);
          errors++;
        end else begin
          exp_r = reply_q.pop_front();
          if (out_if.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                     out_if.status);
            errors++;
          end
          if (out_if.where !== exp_r.where) begin
            $display("%0t: where expected %0d actual %0d", $time, exp_r.where, out_if.where);
            errors++;
          end
          if (out_if.count !== exp_r.count) begin
            $display("%0t: count expected %0d actual %0d", $time, exp_r.count, out_if.count);
            errors++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        seen.func     = in_if.func;
        seen.value    = in_if.value;
        seen.position = in_if.position;
        reply_q.push_back(apply_list_op(seen));
      end
    end
  end

  // Long receiver hold-off, counted here once the stimulus asks for it.
  initial begin
    wait (hold_trigger);
    @(negedge clk_i);
    rx_hold = 1'b1;
    repeat (RxHoldCycles) @(negedge clk_i);
    rx_hold = 1'b0;
  end

  // Stimulus: reset, directed words, then random phases with varied traffic.
  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Empty-list corner cases, edge inserts with clamping and duplicates, deletes, clear.
    add_cmd(FUNC_DELETE, 32'sd5, '0);
    add_cmd(FUNC_CLEAR, 32'sd0, '0);
    add_cmd(FuncNop, 32'sd0, '0);
    add_cmd(FUNC_INSERT, 32'sh7fffffff, '0);
    add_cmd(FUNC_INSERT, 32'sh80000000, 7'd127);
    add_cmd(FUNC_INSERT, 32'sd0, 7'd1);
    add_cmd(FUNC_INSERT, -32'sd1, 7'd0);
    add_cmd(FUNC_INSERT, 32'sd5, 7'd2);
    add_cmd(FUNC_INSERT, 32'sd5, 7'd64);
    add_cmd(FUNC_INSERT, 32'sd9, 7'd3);
    add_cmd(FUNC_DELETE, 32'sd5, 7'd127);
    add_cmd(FUNC_DELETE, 32'sd12345, '0);
    add_cmd(FUNC_DELETE, 32'sh80000000, '0);
    add_cmd(FUNC_DELETE, -32'sd1, '0);
    add_cmd(FuncNop, 32'shffffffff, 7'd127);
    add_cmd(FUNC_CLEAR, 32'shffffffff, 7'd127);
    add_cmd(FUNC_DELETE, 32'sd0, '0);
    add_cmd(FUNC_INSERT, 32'sd3, 7'd100);
    add_cmd(FUNC_DELETE, 32'sd3, '0);
    wait_drained();

    // Insert-heavy phases fill the list; delete-heavy ones drain it again.
    run_phase(250, 72, 24, 1, 0, 0);
    run_phase(250, 25, 70, 1, 49, 0);
    run_phase(250, 50, 45, 2, 0, 49);
    run_phase(250, 72, 24, 1, 25, 25);

    // Receiver holds off while words keep coming, so the block backs up.
    @(negedge clk_i);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_trigger = 1'b1;
    repeat (150) cmd_q.push_back(rand_cmd(50, 45, 2));
    wait_drained();

    run_phase(250, 25, 70, 1, 25, 25);

    if (errors == 0 && reply_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
